### rtl/pts_pkg.sv
// shared types, codes and packing function of the palette to yuv subsampler
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    // default palette depth
    localparam int PALETTE_ENTRIES_DEF = 256;

    // field widths
    localparam int IDX_W   = 8;
    localparam int CH_W    = 8;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 2;
    localparam int LANES   = 4;

    // input and output beat widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;

    // configuration register indexes
    localparam logic [0:0] CFG_FORMAT_MODE = 1'b0;
    localparam logic [0:0] CFG_BIG_ENDIAN  = 1'b1;

    // item operations
    typedef enum logic [0:0] {
        OP_WRITE   = 1'b0,
        OP_CONVERT = 1'b1
    } t_op;

    // output formats
    typedef enum logic [1:0] {
        FMT_UYVY   = 2'd0,
        FMT_YUY2   = 2'd1,
        FMT_YVYU   = 2'd2,
        FMT_PLANAR = 2'd3
    } t_format;

    localparam t_format FORMAT_RESET     = FMT_YUY2;
    localparam logic    BIG_ENDIAN_RESET = 1'b0;

    // one palette colour
    typedef struct packed {
        logic [CH_W-1:0] y;
        logic [CH_W-1:0] u;
        logic [CH_W-1:0] v;
    } t_color;

    // one result
    typedef struct packed {
        logic [CH_W-1:0]   chroma_v;
        logic [CH_W-1:0]   chroma_u;
        logic [CH_W-1:0]   luma_d;
        logic [CH_W-1:0]   luma_c;
        logic [CH_W-1:0]   luma_b;
        logic [CH_W-1:0]   luma_a;
        logic [WORD_W-1:0] packed_word;
    } t_result;

    // byte placement of the packed 4:2:2 word
    function automatic logic [WORD_W-1:0] pack_word(
        input t_format         fmt,
        input logic            big_endian,
        input logic [CH_W-1:0] y0,
        input logic [CH_W-1:0] u,
        input logic [CH_W-1:0] v,
        input logic [CH_W-1:0] y1
    );
        logic [WORD_W-1:0] w;
        unique case (fmt)
            FMT_UYVY:   w = big_endian ? {u, y0, v, y1} : {y1, v, y0, u};
            FMT_YUY2:   w = big_endian ? {y0, u, y1, v} : {v, y1, u, y0};
            FMT_YVYU:   w = big_endian ? {y0, v, y1, u} : {u, y1, v, y0};
            FMT_PLANAR: w = '0;
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/palette_to_yuv_subsampler.sv
// top level of the palette to yuv subsampler
// Usage:
//   Input stream beats carry either a palette write (tuser low) or a convert
//   request (tuser high) with four palette indices. A write stores one 24-bit
//   YUV colour and gives no output beat. A convert gives one output beat:
//   in UYVY, YUY2 or YVYU mode a packed 4:2:2 word from the top pair with the
//   two-way chroma average; in planar 4:2:0 mode the four lumas of the 2x2
//   block with the four-way chroma average. Averages truncate.
//   Configuration is written through the plain write port while idle.
// Timing:
//   Four lookup lanes, each with its own palette copy and one read port, look
//   up all indices of a beat in the accept cycle into their read registers;
//   the merging stage takes the colours from there into its output register.
//   Throughput is one beat per cycle while the receiver does not stall.
// Reset and stall:
//   Reset sets YUY2 mode with little-endian words and empties the pipeline;
//   palette contents are undefined until written. When the receiver stalls,
//   the output beat holds, one more request waits in the lookup stage, and
//   then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module palette_to_yuv_subsampler #(
    parameter int PALETTE_ENTRIES = pts_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration write port
    input  wire                                i_cfg_wr_en,
    input  wire  [0:0]                         i_cfg_index,
    input  wire  [pts_pkg::CFG_W-1:0]          i_cfg_data,
    // input stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // table_slot, table_entry, pix_top_left, pix_top_right,
    // pix_bottom_left, pix_bottom_right
    input  wire  [pts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation
    input  wire  [0:0]                         s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // packed_word, luma_a, luma_b, luma_c, luma_d, chroma_u, chroma_v
    output logic [pts_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import pts_pkg::*;

    t_format             r_format;
    logic                r_big_endian;
    logic                r_s1_valid;
    logic                n_s1_valid;

    logic                in_fire;
    logic                convert_fire;
    logic                write_fire;
    logic                advance;
    t_op                 in_op;
    logic [IDX_W-1:0]    in_slot;
    t_color              in_entry;
    logic [IDX_W-1:0]    lane_idx [LANES];
    t_color              lane_color [LANES];
    t_result             result;

    // input beat fields
    assign in_op       = t_op'(s_axis_tuser[0]);
    assign in_slot     = s_axis_tdata[7:0];
    assign in_entry    = s_axis_tdata[31:8];
    assign lane_idx[0] = s_axis_tdata[39:32];
    assign lane_idx[1] = s_axis_tdata[47:40];
    assign lane_idx[2] = s_axis_tdata[55:48];
    assign lane_idx[3] = s_axis_tdata[63:56];

    // input handshake
    assign s_axis_tready = !r_s1_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign convert_fire  = in_fire && (in_op == OP_CONVERT);
    assign write_fire    = in_fire && (in_op == OP_WRITE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format     <= FORMAT_RESET;
            r_big_endian <= BIG_ENDIAN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FORMAT_MODE: r_format     <= t_format'(i_cfg_data[1:0]);
                CFG_BIG_ENDIAN:  r_big_endian <= i_cfg_data[0];
                default:         r_format     <= r_format;
            endcase
        end
    end

    // lookup stage occupancy
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (convert_fire) begin
            n_s1_valid = 1'b1;
        end else if (advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // lookup lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        pts_lane #(
            .ENTRIES    (PALETTE_ENTRIES)
        ) u_lane (
            .i_clk      (i_clk),
            .i_wr_en    (write_fire),
            .i_wr_slot  (in_slot),
            .i_wr_color (in_entry),
            .i_rd_en    (convert_fire),
            .i_rd_slot  (lane_idx[g]),
            .o_color    (lane_color[g])
        );
    end

    // merging stage
    pts_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_s1_valid),
        .i_colors     (lane_color),
        .i_format     (r_format),
        .i_big_endian (r_big_endian),
        .o_advance    (advance),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    // output beat packing, packed_word in the low bits
    assign m_axis_tdata = result;

endmodule

`default_nettype wire

### rtl/pts_lane.sv
// one lookup lane: a private palette copy with a registered read port
`timescale 1ns / 1ps
`default_nettype none

module pts_lane #(
    parameter int ENTRIES = pts_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire  [pts_pkg::IDX_W-1:0]    i_wr_slot,
    input  pts_pkg::t_color              i_wr_color,
    input  wire                          i_rd_en,
    input  wire  [pts_pkg::IDX_W-1:0]    i_rd_slot,
    output pts_pkg::t_color              o_color
);
    import pts_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    t_color            r_mem [ENTRIES];
    t_color            r_rd_data;
    logic              r_rd_hit;

    logic [XW-1:0]     wr_ext;
    logic [XW-1:0]     rd_ext;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              wr_hit;
    logic              rd_hit;

    // index range checks and address forming
    assign wr_ext  = XW'(i_wr_slot);
    assign rd_ext  = XW'(i_rd_slot);
    assign wr_addr = wr_ext[AW-1:0];
    assign rd_addr = rd_ext[AW-1:0];
    assign wr_hit  = (32'(i_wr_slot) < 32'(ENTRIES));
    assign rd_hit  = (32'(i_rd_slot) < 32'(ENTRIES));

    // palette write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_hit) begin
            r_mem[wr_addr] <= i_wr_color;
        end
    end

    // palette read port, held while no new lookup
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_hit <= rd_hit;
            if (rd_hit) begin
                r_rd_data <= r_mem[rd_addr];
            end
        end
    end

    // index beyond the palette reads as zero
    assign o_color = r_rd_hit ? r_rd_data : '0;

endmodule

`default_nettype wire

### rtl/pts_merge.sv
// merging stage: chroma averages, word packing and the output register
`timescale 1ns / 1ps
`default_nettype none

module pts_merge (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  pts_pkg::t_color      i_colors [pts_pkg::LANES],
    input  pts_pkg::t_format     i_format,
    input  wire                  i_big_endian,
    output logic                 o_advance,
    output logic                 o_valid,
    input  wire                  i_ready,
    output pts_pkg::t_result     o_result
);
    import pts_pkg::*;

    logic                r_valid;
    logic                n_valid;
    t_result             r_result;
    t_result             n_result;

    logic [CH_W+1:0]     sum4_u;
    logic [CH_W+1:0]     sum4_v;
    logic [CH_W:0]       sum2_u;
    logic [CH_W:0]       sum2_v;
    logic [CH_W-1:0]     avg2_u;
    logic [CH_W-1:0]     avg2_v;

    // output register moves when empty or taken
    assign o_advance = !r_valid || i_ready;

    // chroma sums over the lanes
    always_comb begin
        sum2_u = {1'b0, i_colors[0].u} + {1'b0, i_colors[1].u};
        sum2_v = {1'b0, i_colors[0].v} + {1'b0, i_colors[1].v};
        sum4_u = {1'b0, sum2_u}
               + ({2'b0, i_colors[2].u} + {2'b0, i_colors[3].u});
        sum4_v = {1'b0, sum2_v}
               + ({2'b0, i_colors[2].v} + {2'b0, i_colors[3].v});
        avg2_u = sum2_u[CH_W:1];
        avg2_v = sum2_v[CH_W:1];
    end

    // result assembly
    always_comb begin
        n_result        = '0;
        n_result.luma_a = i_colors[0].y;
        n_result.luma_b = i_colors[1].y;
        if (i_format == FMT_PLANAR) begin
            n_result.luma_c   = i_colors[2].y;
            n_result.luma_d   = i_colors[3].y;
            n_result.chroma_u = sum4_u[CH_W+1:2];
            n_result.chroma_v = sum4_v[CH_W+1:2];
        end else begin
            n_result.chroma_u    = avg2_u;
            n_result.chroma_v    = avg2_v;
            n_result.packed_word = pack_word(i_format, i_big_endian, i_colors[0].y,
                                             avg2_u, avg2_v, i_colors[1].y);
        end
    end

    // output valid
    always_comb begin
        n_valid = r_valid;
        if (o_advance) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

### tb/tb_pts_checker.sv
// checker of the palette to yuv subsampler: predicts each result beat and compares it
`timescale 1ns / 1ps
`default_nettype none

module tb_pts_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [0:0]                       i_cfg_index,
    input  wire  [pts_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire                              i_in_valid,
    input  wire                              i_in_ready,
    input  wire  [pts_pkg::IN_DATA_W-1:0]    i_in_data,
    input  wire  [0:0]                       i_in_user,
    input  wire                              i_out_valid,
    input  wire                              i_out_ready,
    input  wire  [pts_pkg::OUT_DATA_W-1:0]   i_out_data,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_checked
);
    import pts_pkg::*;

    // own copy of the palette and the registers
    t_color  colors [256];
    t_format fmt_now;
    logic    big_endian_now;

    // results still owed by the block, oldest first
    t_result owed_results [$];

    // expected result of one pixel group under the current settings
    function automatic t_result subsample_group(input logic [7:0] ia, input logic [7:0] ib,
                                                input logic [7:0] ic, input logic [7:0] id);
        t_color       ca;
        t_color       cb;
        t_color       cc;
        t_color       cd;
        t_result      r;
        logic [9:0]   u_sum;
        logic [9:0]   v_sum;
        logic [3:0][4:0] sh;
        ca = colors[ia];
        cb = colors[ib];
        cc = colors[ic];
        cd = colors[id];
        r = '0;
        r.luma_a = ca.y;
        r.luma_b = cb.y;
        if (fmt_now == FMT_PLANAR) begin
            r.luma_c = cc.y;
            r.luma_d = cd.y;
            u_sum = 10'(ca.u) + 10'(cb.u) + 10'(cc.u) + 10'(cd.u);
            v_sum = 10'(ca.v) + 10'(cb.v) + 10'(cc.v) + 10'(cd.v);
            r.chroma_u = u_sum[9:2];
            r.chroma_v = v_sum[9:2];
        end else begin
            u_sum = 10'(ca.u) + 10'(cb.u);
            v_sum = 10'(ca.v) + 10'(cb.v);
            r.chroma_u = u_sum[8:1];
            r.chroma_v = v_sum[8:1];
            // bit offsets of y1, v, u, y0 (high to low) per format and byte order
            case (fmt_now)
                FMT_UYVY: sh = big_endian_now ? {5'd0, 5'd8, 5'd24, 5'd16}
                                              : {5'd24, 5'd16, 5'd0, 5'd8};
                FMT_YUY2: sh = big_endian_now ? {5'd8, 5'd0, 5'd16, 5'd24}
                                              : {5'd16, 5'd24, 5'd8, 5'd0};
                default:  sh = big_endian_now ? {5'd8, 5'd16, 5'd0, 5'd24}
                                              : {5'd16, 5'd8, 5'd24, 5'd0};
            endcase
            r.packed_word = (32'(ca.y) << sh[0]) | (32'(r.chroma_u) << sh[1])
                          | (32'(r.chroma_v) << sh[2]) | (32'(cb.y) << sh[3]);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        fmt_now = FORMAT_RESET;
        big_endian_now = BIG_ENDIAN_RESET;
        foreach (colors[k]) colors[k] = '0;
    end

    // watch the three channels at each rising edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            fmt_now = FORMAT_RESET;
            big_endian_now = BIG_ENDIAN_RESET;
        end else begin
            // register write
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_FORMAT_MODE)
                    fmt_now = t_format'(i_cfg_data[1:0]);
                else
                    big_endian_now = i_cfg_data[0];
            end
            // result beat against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                got = t_result'(i_out_data);
                if (owed_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = owed_results.pop_front();
                    o_checked++;
                    check_field("packed_word", want.packed_word, got.packed_word);
                    check_field("luma_a", 32'(want.luma_a), 32'(got.luma_a));
                    check_field("luma_b", 32'(want.luma_b), 32'(got.luma_b));
                    check_field("luma_c", 32'(want.luma_c), 32'(got.luma_c));
                    check_field("luma_d", 32'(want.luma_d), 32'(got.luma_d));
                    check_field("chroma_u", 32'(want.chroma_u), 32'(got.chroma_u));
                    check_field("chroma_v", 32'(want.chroma_v), 32'(got.chroma_v));
                end
            end
            // input beat: palette write or pixel group
            if (i_in_valid && i_in_ready) begin
                if (t_op'(i_in_user) == OP_WRITE)
                    colors[i_in_data[7:0]] = t_color'(i_in_data[31:8]);
                else
                    owed_results.push_back(subsample_group(i_in_data[39:32], i_in_data[47:40],
                                                           i_in_data[55:48], i_in_data[63:56]));
            end
        end
        o_pending = owed_results.size();
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench top of the palette to yuv subsampler: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import pts_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 172;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [0:0]              i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // table_slot, table_entry, pix_top_left, pix_top_right,
    // pix_bottom_left, pix_bottom_right
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    // operation
    logic [0:0]              s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // packed_word, luma_a, luma_b, luma_c, luma_d, chroma_u, chroma_v
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    int  fail_count;
    int  owed_count;
    int  compared_count;
    int  palette_writes;
    int  conversions;
    int  reg_writes;
    int  idle_cycles;
    bit  hold_req;
    bit  quiet;
    bit  slot_loaded [256];
    logic [7:0] loaded_slots [$];

    palette_to_yuv_subsampler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tb_pts_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (fail_count),
        .o_pending   (owed_count),
        .o_checked   (compared_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stall bursts, calm stretches, one long hold-off
    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (quiet || calm_left > 0) begin
                m_axis_tready = 1'b1;
                if (calm_left > 0) calm_left--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                case ($urandom_range(0, 15))
                    0, 1: begin
                        stall_left = $urandom_range(0, 14);
                        m_axis_tready = 1'b0;
                    end
                    2: begin
                        calm_left = $urandom_range(20, 80);
                        m_axis_tready = 1'b1;
                    end
                    default: m_axis_tready = 1'b1;
                endcase
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [IN_DATA_W-1:0] beat_fields(
        input logic [7:0] slot, input logic [23:0] color,
        input logic [7:0] ia, input logic [7:0] ib, input logic [7:0] ic, input logic [7:0] id);
        return {id, ic, ib, ia, color, slot};
    endfunction

    // offer one beat and hold it until accepted
    task automatic send_beat(input t_op op, input logic [IN_DATA_W-1:0] data);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = data;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_WRITE) palette_writes++;
        else conversions++;
    endtask

    task automatic source_gap(input int n);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        for (int c = 1; c < n; c++) @(negedge i_clk);
    endtask

    task automatic load_color(input logic [7:0] slot, input logic [23:0] color);
        send_beat(OP_WRITE, beat_fields(slot, color, 8'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom)));
        if (!slot_loaded[slot]) begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
    endtask

    task automatic convert_group(input logic [7:0] ia, input logic [7:0] ib,
                                 input logic [7:0] ic, input logic [7:0] id);
        send_beat(OP_CONVERT, beat_fields(8'($urandom), 24'($urandom), ia, ib, ic, id));
    endtask

    // stop sending until every expected result is back, then let the pipe settle
    task automatic drain;
        source_gap(1);
        while (owed_count != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [0:0] index, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        reg_writes++;
    endtask

    function automatic logic [7:0] any_loaded;
        return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
    endfunction

    // one random beat: palette write or conversion over loaded entries
    task automatic random_item;
        logic [23:0] color;
        if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 7))
                0:       color = 24'hffffff;
                1:       color = 24'h000000;
                default: color = 24'($urandom);
            endcase
            load_color(8'($urandom_range(0, 255)), color);
        end else
            convert_group(any_loaded(), any_loaded(), any_loaded(), any_loaded());
        if (!quiet && $urandom_range(0, 7) == 0)
            source_gap($urandom_range(1, 15));
    endtask

    initial begin
        t_format mode;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_FORMAT_MODE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_WRITE;
        hold_req      = 1'b0;
        quiet         = 1'b0;
        palette_writes = 0;
        conversions    = 0;
        reg_writes     = 0;
        idle_cycles    = 0;
        foreach (slot_loaded[k]) slot_loaded[k] = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extreme colors at the end slots, reset mode first
        load_color(8'd0, 24'hffffff);
        load_color(8'd255, 24'h000000);
        load_color(8'd1, 24'h80ff01);
        load_color(8'd2, 24'h7f01fe);
        convert_group(8'd0, 8'd0, 8'd0, 8'd0);
        convert_group(8'd255, 8'd255, 8'd255, 8'd255);
        convert_group(8'd0, 8'd255, 8'd255, 8'd0);
        convert_group(8'd1, 8'd2, 8'd1, 8'd2);

        // directed: every format in both byte orders, excess register bit set at times
        for (int m = 0; m < 4; m++) begin
            for (int be = 0; be < 2; be++) begin
                drain();
                set_reg(CFG_FORMAT_MODE, CFG_W'(m));
                set_reg(CFG_BIG_ENDIAN, {m[0], 1'(be)});
                convert_group(8'd0, 8'd255, 8'd1, 8'd2);
                convert_group(8'd2, 8'd1, 8'd255, 8'd0);
            end
        end

        // random phases, each with its own settings
        for (int p = 0; p < PHASES; p++) begin
            drain();
            quiet = (p == PHASES - 1);
            mode = (p == 0) ? FMT_PLANAR : t_format'($urandom_range(0, 3));
            set_reg(CFG_FORMAT_MODE, mode);
            set_reg(CFG_BIG_ENDIAN, CFG_W'($urandom_range(0, 3)));
            if (p == 1) hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) random_item();
        end
        drain();

        $display("Covered %0d palette writes and %0d conversions across %0d register writes,",
                 palette_writes, conversions, reg_writes);
        $display("all four formats in both byte orders; %0d result beats compared.",
                 compared_count);
        if (fail_count == 0 && owed_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
